>>> rtl/core/mrsp_pkg.sv
// Shared types, byte codes and the message length table for the MIDI parser.
// Used by mrsp_parse, mrsp_out and midi_running_status_parser_core.
`default_nettype none

package mrsp_pkg;

  // Byte codes with a fixed meaning on the MIDI wire.
  localparam logic [7:0] BYTE_SYS_FIRST   = 8'hF0;  // first system status, also SysEx start
  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
  localparam logic [7:0] BYTE_RT_FIRST    = 8'hF8;  // real-time range starts here
  localparam logic [7:0] BYTE_MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] BYTE_SONG_POS    = 8'hF2;
  localparam logic [7:0] BYTE_SONG_SEL    = 8'hF3;
  localparam logic [3:0] NIB_PROG_CHANGE  = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS   = 4'hD;

  // Message lengths, status byte included.
  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // Widths of the stream words.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  // One completed message.
  typedef struct packed {
    logic [1:0] length;
    logic [6:0] data2;
    logic [6:0] data1;
    logic [7:0] status;
  } msg_t;

  // Full message length for a status byte.
  function automatic logic [1:0] msg_len(input logic [7:0] st);
    logic [1:0] len;
    len = LEN_THREE;
    if (st >= BYTE_SYS_FIRST) begin
      if (st == BYTE_MTC_QFRAME || st == BYTE_SONG_SEL) begin
        len = LEN_TWO;
      end else if (st == BYTE_SONG_POS) begin
        len = LEN_THREE;
      end else begin
        len = LEN_ONE;
      end
    end else if (st[7:4] == NIB_PROG_CHANGE || st[7:4] == NIB_CHAN_PRESS) begin
      len = LEN_TWO;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mrsp_parse.sv
// Parser state and next-state logic: takes one byte per step and flags a
// completed message. Depends on mrsp_pkg.
`default_nettype none

module mrsp_parse (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          byte_valid_i,  // a byte waits in the input register
  input  wire logic [7:0]    byte_i,
  input  wire logic          step_i,        // commit this byte to the state
  output logic               res_valid_o,   // this byte completes a message
  output mrsp_pkg::msg_t     res_o
);

  logic [7:0] running_status_q, running_status_d;
  logic       in_sysex_q, in_sysex_d;
  logic [1:0] byte_count_q, byte_count_d;
  logic [1:0] expected_len_q, expected_len_d;
  logic [7:0] held_status_q, held_status_d;
  logic [6:0] held_data_q, held_data_d;
  logic [1:0] rs_len;
  logic [1:0] st_len;
  logic       emit;

  assign rs_len = mrsp_pkg::msg_len(running_status_q);
  assign st_len = mrsp_pkg::msg_len(byte_i);

  // Next state and result for the byte in the input register.
  always_comb begin
    running_status_d = running_status_q;
    in_sysex_d       = in_sysex_q;
    byte_count_d     = byte_count_q;
    expected_len_d   = expected_len_q;
    held_status_d    = held_status_q;
    held_data_d      = held_data_q;
    emit             = 1'b0;
    res_o            = '0;

    if (byte_i[7]) begin
      if (byte_i >= mrsp_pkg::BYTE_RT_FIRST) begin
        // Real-time: out at once, state untouched.
        emit         = 1'b1;
        res_o.status = byte_i;
        res_o.length = mrsp_pkg::LEN_ONE;
      end else if (byte_i == mrsp_pkg::BYTE_SYSEX_START ||
                   byte_i == mrsp_pkg::BYTE_SYSEX_END) begin
        in_sysex_d       = (byte_i == mrsp_pkg::BYTE_SYSEX_START);
        byte_count_d     = 2'd0;
        expected_len_d   = mrsp_pkg::LEN_NONE;
        running_status_d = 8'h00;
      end else begin
        // Any other status opens a new message.
        in_sysex_d       = 1'b0;
        held_status_d    = byte_i;
        byte_count_d     = 2'd1;
        expected_len_d   = st_len;
        running_status_d = (byte_i < mrsp_pkg::BYTE_SYS_FIRST) ? byte_i : 8'h00;
        if (st_len == mrsp_pkg::LEN_ONE) begin
          byte_count_d = 2'd0;
          emit         = 1'b1;
          res_o.status = byte_i;
          res_o.length = mrsp_pkg::LEN_ONE;
        end
      end
    end else if (!in_sysex_q) begin
      unique case (byte_count_q)
        2'd0: begin
          // No open message: fall back on running status if there is one.
          if (running_status_q != 8'h00) begin
            held_status_d  = running_status_q;
            held_data_d    = byte_i[6:0];
            byte_count_d   = 2'd2;
            expected_len_d = rs_len;
            if (rs_len != mrsp_pkg::LEN_THREE) begin
              byte_count_d = 2'd0;
              emit         = 1'b1;
              res_o.status = running_status_q;
              res_o.data1  = byte_i[6:0];
              res_o.length = mrsp_pkg::LEN_TWO;
            end
          end
        end
        2'd1: begin
          held_data_d  = byte_i[6:0];
          byte_count_d = 2'd2;
          if (expected_len_q != mrsp_pkg::LEN_THREE) begin
            byte_count_d = 2'd0;
            emit         = 1'b1;
            res_o.status = held_status_q;
            res_o.data1  = byte_i[6:0];
            res_o.length = mrsp_pkg::LEN_TWO;
          end
        end
        default: begin
          // Third byte completes the message.
          byte_count_d = 2'd0;
          emit         = 1'b1;
          res_o.status = held_status_q;
          res_o.data1  = held_data_q;
          res_o.data2  = byte_i[6:0];
          res_o.length = mrsp_pkg::LEN_THREE;
        end
      endcase
    end
  end

  assign res_valid_o = byte_valid_i & emit;

  // State registers, updated once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_status_q <= 8'h00;
      in_sysex_q       <= 1'b0;
      byte_count_q     <= 2'd0;
      expected_len_q   <= mrsp_pkg::LEN_NONE;
      held_status_q    <= 8'h00;
      held_data_q      <= 7'h00;
    end else if (step_i) begin
      running_status_q <= running_status_d;
      in_sysex_q       <= in_sysex_d;
      byte_count_q     <= byte_count_d;
      expected_len_q   <= expected_len_d;
      held_status_q    <= held_status_d;
      held_data_q      <= held_data_d;
    end
  end

  // Inside SysEx no message can be open.
  a_sysex_no_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sysex_q |-> byte_count_q == 2'd0)
    else $error("message open inside SysEx");

  // Running status is either empty or a channel status byte.
  a_rs_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_status_q == 8'h00 ||
    (running_status_q[7] && running_status_q < mrsp_pkg::BYTE_SYS_FIRST))
    else $error("running status holds a non-channel byte");

  // A one-byte result carries zero data fields.
  a_len1_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.length == mrsp_pkg::LEN_ONE) |->
    (res_o.data1 == 7'h00 && res_o.data2 == 7'h00))
    else $error("one-byte message with data");

  // A result always has a length and a status byte.
  a_res_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.length != mrsp_pkg::LEN_NONE && res_o.status[7]))
    else $error("result without length or status");

endmodule

`default_nettype wire

>>> rtl/core/mrsp_out.sv
// Result register of the parser: holds one message word until the receiver
// takes it. Depends on mrsp_pkg.
`default_nettype none

module mrsp_out (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,   // a new message is written
  input  mrsp_pkg::msg_t            msg_i,
  output logic                      free_o,   // room for a message this cycle
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [mrsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic           valid_q, valid_d;
  mrsp_pkg::msg_t msg_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload word, no reset needed.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      msg_q <= msg_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = msg_q;

  // A load only happens when the register has room.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register overwritten");

  // A word that is loaded is shown in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded word not shown");

  // Without a load the flag only drops on a taken word.
  a_drop_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !load_i && !m_axis_tready_i) |=> valid_q)
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

>>> rtl/core/midi_running_status_parser_core.sv
// MIDI receive parser with running status: top level.
// Instantiates mrsp_parse and mrsp_out; depends on mrsp_pkg.
//
// Use: received MIDI bytes enter on the slave stream, one byte per word.
// Completed messages of one to three bytes leave on the master stream, one
// message per word: status, first data, second data and length. Data fields
// beyond the message length are zero. Real-time bytes come out at once as
// one-byte messages; SysEx bodies and data bytes without an open message
// and without running status produce no word.
// Path: a byte accepted from the slave stream lands in the input register, is
// parsed from there and its message is written to the result register,
// which offers it on the master stream. Throughput is one byte per cycle
// while no message waits on a full result register; the parser state is a
// few small registers updated together once per byte.
// Stall: while the receiver holds tready low the result register keeps its
// word; bytes that produce no message still pass, and the input side stops
// once a byte that completes a message must wait for the result register.
// Reset clears the parser state (no running status, no open message, not in
// SysEx) and empties both registers.
`default_nettype none

module midi_running_status_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [mrsp_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,  // [7:0] midi_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] msg_status, [14:8] msg_data1, [21:15] msg_data2, [23:22] msg_length
  output logic [mrsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic           in_valid_q, in_valid_d;
  logic [7:0]     in_byte_q;
  logic           res_valid;
  mrsp_pkg::msg_t res;
  logic           out_free;
  logic           advance;

  // The byte moves on unless its message finds the result register full.
  assign advance         = in_valid_q && (!res_valid || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Input register word.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  mrsp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_valid_q),
    .byte_i       (in_byte_q),
    .step_i       (advance),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  mrsp_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance && res_valid),
    .msg_i           (res),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // A byte that yields no message never waits.
  a_nomsg_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !res_valid) |-> advance)
    else $error("byte without message stalled");

  // A stalled byte stays in the input register.
  a_in_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled input byte lost");

  // The input side only blocks when a message waits on a full result register.
  a_block_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && res_valid && !out_free))
    else $error("input blocked without cause");

endmodule

`default_nettype wire

>>> bench/midi_running_status_parser_core_checker.sv
`timescale 1ns / 100ps
// Checker for the MIDI running-status parser: predicts each completed message
// from the accepted input bytes and compares it with the output stream.
// Depends on mrsp_pkg for the message word layout and the byte codes.

module midi_running_status_parser_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] midi_byte
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // [7:0] msg_status, [14:8] msg_data1, [21:15] msg_data2, [23:22] msg_length
  input  logic [23:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [7:0] NO_STATUS = 8'h00;

  // Parser state as the prediction sees it.
  logic [7:0] run_status;
  logic       sysex_open;
  logic [1:0] held_count;
  logic [1:0] full_length;
  logic [7:0] held_status;
  logic [6:0] held_data1;

  mrsp_pkg::msg_t expected_msgs [$];
  int             fails;

  // Full length of a message, status byte included.
  function automatic logic [1:0] length_of(input logic [7:0] st);
    logic [1:0] len;
    if (st >= mrsp_pkg::BYTE_SYS_FIRST) begin
      unique case (st)
        mrsp_pkg::BYTE_MTC_QFRAME, mrsp_pkg::BYTE_SONG_SEL: len = mrsp_pkg::LEN_TWO;
        mrsp_pkg::BYTE_SONG_POS:                            len = mrsp_pkg::LEN_THREE;
        default:                                            len = mrsp_pkg::LEN_ONE;
      endcase
    end else begin
      unique case (st[7:4])
        mrsp_pkg::NIB_PROG_CHANGE, mrsp_pkg::NIB_CHAN_PRESS: len = mrsp_pkg::LEN_TWO;
        default:                                             len = mrsp_pkg::LEN_THREE;
      endcase
    end
    return len;
  endfunction

  // Advance the parser state by one byte; returns 1 when a message completes.
  function automatic bit predict_byte(input logic [7:0] b, output mrsp_pkg::msg_t m);
    m = '0;
    if (b[7]) begin
      // Real-time bytes pass straight through and touch nothing else.
      if (b >= mrsp_pkg::BYTE_RT_FIRST) begin
        m.status = b;
        m.length = mrsp_pkg::LEN_ONE;
        return 1'b1;
      end
      // SysEx start and end close any open message and cancel running status.
      if (b == mrsp_pkg::BYTE_SYSEX_START || b == mrsp_pkg::BYTE_SYSEX_END) begin
        sysex_open  = (b == mrsp_pkg::BYTE_SYSEX_START);
        held_count  = 2'd0;
        full_length = mrsp_pkg::LEN_NONE;
        run_status  = NO_STATUS;
        return 1'b0;
      end
      sysex_open  = 1'b0;
      held_status = b;
      held_count  = 2'd1;
      full_length = length_of(b);
      run_status  = (b < mrsp_pkg::BYTE_SYS_FIRST) ? b : NO_STATUS;
      if (full_length == mrsp_pkg::LEN_ONE) begin
        held_count = 2'd0;
        m.status   = b;
        m.length   = mrsp_pkg::LEN_ONE;
        return 1'b1;
      end
      return 1'b0;
    end
    if (sysex_open) begin
      return 1'b0;
    end
    // A data byte with no open message reuses the running status.
    if (held_count == 2'd0) begin
      if (run_status == NO_STATUS) begin
        return 1'b0;
      end
      held_status = run_status;
      full_length = length_of(run_status);
    end
    if (held_count != 2'd2) begin
      held_data1 = b[6:0];
      held_count = 2'd2;
      if (full_length != mrsp_pkg::LEN_THREE) begin
        held_count = 2'd0;
        m.status   = held_status;
        m.data1    = b[6:0];
        m.length   = mrsp_pkg::LEN_TWO;
        return 1'b1;
      end
      return 1'b0;
    end
    // Third byte completes a three-byte message.
    held_count = 2'd0;
    m.status   = held_status;
    m.data1    = held_data1;
    m.data2    = b[6:0];
    m.length   = mrsp_pkg::LEN_THREE;
    return 1'b1;
  endfunction

  // Compare outgoing words first, then predict from the incoming byte.
  always @(posedge clk_i or negedge rst_ni) begin : track
    mrsp_pkg::msg_t want;
    mrsp_pkg::msg_t got;
    mrsp_pkg::msg_t pred;
    if (!rst_ni) begin
      run_status   = NO_STATUS;
      sysex_open   = 1'b0;
      held_count   = 2'd0;
      full_length  = mrsp_pkg::LEN_NONE;
      held_status  = NO_STATUS;
      held_data1   = '0;
      expected_msgs.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = mrsp_pkg::msg_t'(m_tdata_i);
        if (expected_msgs.size() == 0) begin
          $display("%0t: unexpected message word %h, nothing expected", $time, m_tdata_i);
          fails++;
        end else begin
          want = expected_msgs.pop_front();
          if (got.status != want.status) begin
            $display("%0t: msg_status mismatch: expected %h, actual %h",
                     $time, want.status, got.status);
            fails++;
          end
          if (got.data1 != want.data1) begin
            $display("%0t: msg_data1 mismatch: expected %h, actual %h",
                     $time, want.data1, got.data1);
            fails++;
          end
          if (got.data2 != want.data2) begin
            $display("%0t: msg_data2 mismatch: expected %h, actual %h",
                     $time, want.data2, got.data2);
            fails++;
          end
          if (got.length != want.length) begin
            $display("%0t: msg_length mismatch: expected %0d, actual %0d",
                     $time, want.length, got.length);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (predict_byte(s_tdata_i, pred)) begin
          expected_msgs.push_back(pred);
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_msgs.size();
    end
  end

endmodule

>>> bench/midi_running_status_parser_core_test.sv
`timescale 1ns / 100ps
// Top of the MIDI running-status parser bench: clock, reset, byte stimulus,
// output back-pressure and the verdict. Needs mrsp_pkg, the parser core and
// midi_running_status_parser_core_checker.

module midi_running_status_parser_core_test;

  localparam int         STALL_LIMIT   = 1000;
  localparam int         RANDOM_ITEMS  = 1850;
  localparam int         DRAIN_CYCLES  = 8;
  localparam logic [7:0] BYTE_UNDEF_F4 = 8'hF4;
  localparam logic [7:0] BYTE_UNDEF_F5 = 8'hF5;
  localparam logic [7:0] BYTE_TUNE_REQ = 8'hF6;
  localparam logic [7:0] BYTE_RT_RESET = 8'hFF;
  localparam int         DIRECTED_LEN  = 30;

  logic        clk_i    = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  int fail_count;
  int pending;
  int src_idle_pct  = 16;
  int sink_idle_pct = 51;
  int quiet_cycles  = 0;
  int items_sent    = 0;

  // Extremes, every message length, real-time inside a message, SysEx
  // entry and exit, a status byte inside SysEx, F7 outside SysEx followed by
  // an orphan data byte, and the undefined system status bytes.
  logic [7:0] directed_seq [0:DIRECTED_LEN-1] = '{
    8'h80, 8'h00, 8'h00,
    8'h7F, 8'h7F,
    8'hC5, 8'h7F, 8'h01,
    8'h90, mrsp_pkg::BYTE_RT_FIRST, 8'h3C, BYTE_RT_RESET, 8'h40,
    mrsp_pkg::BYTE_SYSEX_START, 8'h12, 8'hB0, 8'h7F, 8'h00,
    mrsp_pkg::BYTE_SYSEX_END, 8'h55,
    BYTE_UNDEF_F4, BYTE_UNDEF_F5, BYTE_TUNE_REQ,
    mrsp_pkg::BYTE_MTC_QFRAME, 8'h00,
    mrsp_pkg::BYTE_SONG_POS, 8'h7F, 8'h7F,
    mrsp_pkg::BYTE_SONG_SEL, 8'h05
  };

  midi_running_status_parser_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  midi_running_status_parser_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Random back-pressure on the message stream.
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Count cycles in which no word moves on either side.
  always @(posedge clk_i) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one byte, with random idle cycles ahead of it, until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_data();
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] rand_chan_status();
    return 8'($urandom_range(8'h80, 8'hEF));
  endfunction

  function automatic logic [7:0] rand_realtime();
    return 8'($urandom_range(mrsp_pkg::BYTE_RT_FIRST, 8'hFF));
  endfunction

  // Data byte, now and then preceded by a real-time byte.
  task automatic send_data(input logic [7:0] b);
    if ($urandom_range(0, 9) == 0) begin
      send_byte(rand_realtime());
    end
    send_byte(b);
  endtask

  // One random run: mostly well-formed messages, some broken ones and noise.
  task automatic send_random_run();
    int         kind;
    int         n;
    int         reps;
    logic [7:0] st;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // Channel message, then up to three repeats under running status.
      st = rand_chan_status();
      n  = (st[7:4] == mrsp_pkg::NIB_PROG_CHANGE ||
            st[7:4] == mrsp_pkg::NIB_CHAN_PRESS) ? 1 : 2;
      send_byte(st);
      if ($urandom_range(0, 9) == 0) begin
        n = n - 1;
      end
      reps = $urandom_range(0, 3);
      for (int r = 0; r <= reps; r++) begin
        for (int i = 0; i < n; i++) begin
          send_data(rand_data());
        end
        n = (st[7:4] == mrsp_pkg::NIB_PROG_CHANGE ||
             st[7:4] == mrsp_pkg::NIB_CHAN_PRESS) ? 1 : 2;
      end
    end else if (kind < 50) begin
      // Bare data bytes: running status or dropped.
      n = $urandom_range(1, 4);
      repeat (n) send_data(rand_data());
    end else if (kind < 62) begin
      case ($urandom_range(0, 5))
        0: begin
          send_byte(mrsp_pkg::BYTE_MTC_QFRAME);
          send_data(rand_data());
        end
        1: begin
          send_byte(mrsp_pkg::BYTE_SONG_POS);
          send_data(rand_data());
          send_data(rand_data());
        end
        2: begin
          send_byte(mrsp_pkg::BYTE_SONG_SEL);
          send_data(rand_data());
        end
        3: send_byte(BYTE_UNDEF_F4);
        4: send_byte(BYTE_UNDEF_F5);
        default: send_byte(BYTE_TUNE_REQ);
      endcase
    end else if (kind < 74) begin
      // SysEx block, closed by F7 or cut short by a channel status byte.
      send_byte(mrsp_pkg::BYTE_SYSEX_START);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) begin
          send_byte(rand_realtime());
        end
        send_byte(rand_data());
      end
      if ($urandom_range(0, 3) == 0) begin
        send_byte(rand_chan_status());
      end else begin
        send_byte(mrsp_pkg::BYTE_SYSEX_END);
      end
    end else if (kind < 84) begin
      send_byte(rand_realtime());
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      send_byte(directed_seq[i]);
    end

    // Three idling phases: sender light and receiver heavy, swapped, none.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct  <= 51;
        sink_idle_pct <= 16;
      end else if (phase == 2) begin
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
      end
      while (items_sent < DIRECTED_LEN + (phase + 1) * RANDOM_ITEMS / 3) begin
        send_random_run();
      end
    end
    s_tvalid <= 1'b0;

    // Drain the result stream, then allow for the parser latency.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending != 0) begin
      $display("%0t: %0d expected messages never arrived", $time, pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mrsp_pkg.sv
rtl/core/mrsp_parse.sv
rtl/core/mrsp_out.sv
rtl/core/midi_running_status_parser_core.sv
bench/midi_running_status_parser_core_checker.sv
bench/midi_running_status_parser_core_test.sv
